/* design/assert_macros.svh */
// Assertion macros shared by the design files.
// Each check is sampled on the rising clock edge and is held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every edge.
`define SNM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define SNM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SNM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/snm_pkg.sv */
package snm_pkg;

    localparam int NUM_CHANNELS = 6;

    localparam int CH_W       = 3;
    localparam int ROW_W      = CH_W + 1;
    localparam int ACC_ROWS   = 2 ** ROW_W;
    localparam int PAR_ROWS   = 2 ** CH_W;
    localparam int ACC_W      = 32;
    localparam int NOISE_W    = 17;
    localparam int GAIN_W     = 16;
    localparam int ORD_W      = 4;
    localparam int SH_W       = ORD_W + 1;
    localparam int PROD_W     = ACC_W + GAIN_W;
    localparam int LEVEL_W    = 16;
    localparam int SLOT_W     = 6;
    localparam int VAL_W      = 8;
    localparam int GAIN_SHIFT = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // request kinds
    localparam logic [1:0] REQ_LIGHT = 2'd0;
    localparam logic [1:0] REQ_MOTOR = 2'd1;
    localparam logic [1:0] REQ_PARAM = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ORDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_EN     = 2'd2;

    localparam logic signed [GAIN_W-1:0]  MOTOR_GAIN_RST  = 16'sd2000;
    localparam logic [ORD_W-1:0]          MOTOR_ORDER_RST = 4'd10;
    localparam logic signed [LEVEL_W-1:0] MOTOR_OFFSET    = 16'sd512;
    localparam logic [SLOT_W-1:0]         SLOT_LIGHT_BASE = 6'd30;
    localparam logic [SLOT_W-1:0]         SLOT_MOTOR_BASE = 6'd24;

    typedef logic [3:0][ACC_W-1:0] t_acc_row;

    typedef struct packed {
        logic            vld;
        logic            is_motor;
        logic [CH_W-1:0] chan;
    } t_tag;

    typedef struct packed {
        logic [ORD_W-1:0]   ord_b;
        logic [ORD_W-1:0]   ord_a;
        logic [GAIN_W-1:0]  gain_b;
        logic [GAIN_W-1:0]  gain_a;
        logic [LEVEL_W-1:0] offset;
    } t_par;

    typedef struct packed {
        logic [SH_W-1:0]             k1a;
        logic [SH_W-1:0]             k2a;
        logic [SH_W-1:0]             k1b;
        logic [SH_W-1:0]             k2b;
        logic signed [GAIN_W-1:0]    gain_a;
        logic signed [GAIN_W-1:0]    gain_b;
        logic signed [LEVEL_W-1:0]   offset;
    } t_coef;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        t_acc_row         data;
    } t_acc_wr;

    typedef struct packed {
        t_tag                      tag;
        logic signed [ACC_W-1:0]   ya;
        logic signed [ACC_W-1:0]   yb;
        logic signed [GAIN_W-1:0]  gain_a;
        logic signed [GAIN_W-1:0]  gain_b;
        logic signed [LEVEL_W-1:0] offset;
    } t_mix_in;

    typedef struct packed {
        logic               vld;
        logic [SLOT_W-1:0]  slot;
        logic [VAL_W-1:0]   value;
        logic [LEVEL_W-1:0] level;
    } t_res;

    // accumulator row: motors sit in the upper half
    function automatic logic [ROW_W-1:0] row_of(input t_tag tag);
        return {tag.is_motor, tag.chan};
    endfunction

endpackage

/* design/snm_acc_mem.sv */
module snm_acc_mem import snm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [ROW_W-1:0] i_rd_row,
    output t_acc_row         o_rd_data,
    input  t_acc_wr          i_wr
);

    t_acc_row              r_mem [ACC_ROWS];
    t_acc_row              r_rd_data;
    logic [ACC_ROWS-1:0]   r_row_ok;
    logic                  r_rd_ok;

    // rows never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_row_ok[i_wr.row] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_row_ok[i_rd_row];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.row] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

/* design/snm_par_mem.sv */
module snm_par_mem import snm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [CH_W-1:0] i_rd_chan,
    output t_par            o_rd_data,
    input  logic            i_wr_en,
    input  logic [CH_W-1:0] i_wr_chan,
    input  t_par            i_wr_data
);

    t_par                r_mem [PAR_ROWS];
    t_par                r_rd_data;
    logic [PAR_ROWS-1:0] r_row_ok;
    logic                r_rd_ok;

    // channels never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_ok[i_wr_chan] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_row_ok[i_rd_chan];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_chan] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_chan];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

/* design/snm_cascade.sv */
module snm_cascade import snm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  t_tag                      i_tag,
    input  t_acc_row                  i_acc,
    input  logic signed [NOISE_W-1:0] i_noise_a,
    input  logic signed [NOISE_W-1:0] i_noise_b,
    input  t_coef                     i_coef,
    output t_tag                      o_p2_tag,
    output t_acc_wr                   o_wr,
    output t_mix_in                   o_mix
);

    function automatic logic signed [ACC_W-1:0] leak(
        input logic signed [ACC_W-1:0] acc,
        input logic [SH_W-1:0]         k,
        input logic signed [ACC_W-1:0] x
    );
        return acc - (acc >>> k) + x;
    endfunction

    logic signed [ACC_W-1:0] na_ext, nb_ext;
    logic signed [ACC_W-1:0] acc0_n, acc2_n, y1a, y1b;
    logic signed [ACC_W-1:0] acc1_n, acc3_n, ya, yb;

    t_tag                      r_p2_tag, r_p3_tag;
    logic signed [ACC_W-1:0]   r_acc0_n, r_acc2_n, r_acc1, r_acc3, r_y1a, r_y1b;
    logic [SH_W-1:0]           r_k2a, r_k2b;
    logic signed [GAIN_W-1:0]  r_gain_a, r_gain_b, r_p3_gain_a, r_p3_gain_b;
    logic signed [LEVEL_W-1:0] r_offset, r_p3_offset;
    logic signed [ACC_W-1:0]   r_ya, r_yb;

    // first stage of both cascades
    always_comb begin
        na_ext = ACC_W'(i_noise_a);
        nb_ext = ACC_W'(i_noise_b);
        acc0_n = leak($signed(i_acc[0]), i_coef.k1a, na_ext);
        acc2_n = leak($signed(i_acc[2]), i_coef.k1b, nb_ext);
        y1a    = acc0_n >>> i_coef.k1a;
        y1b    = acc2_n >>> i_coef.k1b;
    end

    // second stage, fed by the first
    always_comb begin
        acc1_n = leak(r_acc1, r_k2a, r_y1a);
        acc3_n = leak(r_acc3, r_k2b, r_y1b);
        ya     = acc1_n >>> r_k2a;
        yb     = acc3_n >>> r_k2b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_tag <= '0;
            r_p3_tag <= '0;
        end else if (i_adv) begin
            r_p2_tag <= i_tag;
            r_p3_tag <= r_p2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_acc0_n    <= acc0_n;
            r_acc2_n    <= acc2_n;
            r_acc1      <= $signed(i_acc[1]);
            r_acc3      <= $signed(i_acc[3]);
            r_y1a       <= y1a;
            r_y1b       <= y1b;
            r_k2a       <= i_coef.k2a;
            r_k2b       <= i_coef.k2b;
            r_gain_a    <= i_coef.gain_a;
            r_gain_b    <= i_coef.gain_b;
            r_offset    <= i_coef.offset;
            r_ya        <= ya;
            r_yb        <= yb;
            r_p3_gain_a <= r_gain_a;
            r_p3_gain_b <= r_gain_b;
            r_p3_offset <= r_offset;
        end
    end

    // write the row back as the request leaves the second stage
    assign o_wr.en   = r_p2_tag.vld && i_adv;
    assign o_wr.row  = row_of(r_p2_tag);
    assign o_wr.data = {acc3_n, r_acc2_n, acc1_n, r_acc0_n};

    assign o_p2_tag = r_p2_tag;

    assign o_mix.tag    = r_p3_tag;
    assign o_mix.ya     = r_ya;
    assign o_mix.yb     = r_yb;
    assign o_mix.gain_a = r_p3_gain_a;
    assign o_mix.gain_b = r_p3_gain_b;
    assign o_mix.offset = r_p3_offset;

endmodule

/* design/snm_mix.sv */
module snm_mix import snm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_mix_in i_mix,
    output t_res    o_res
);

    localparam int V_W = LEVEL_W - 2;
    localparam logic signed [V_W-1:0] V_MAX       = V_W'(255);
    localparam logic signed [V_W-1:0] V_MIN_LIGHT = V_W'(0);
    localparam logic signed [V_W-1:0] V_MIN_MOTOR = V_W'(1);

    logic signed [PROD_W-1:0] pa, pb;
    t_tag                     r_tag;
    logic signed [PROD_W-1:0] r_pa, r_pb;
    logic [LEVEL_W-1:0]       r_offset;
    logic [LEVEL_W-1:0]       level;
    logic signed [V_W-1:0]    v, v_min;
    logic [VAL_W-1:0]         value;

    assign pa = $signed(i_mix.ya) * $signed(i_mix.gain_a);
    assign pb = $signed(i_mix.yb) * $signed(i_mix.gain_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_adv) begin
            r_tag <= i_mix.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pa     <= pa;
            r_pb     <= pb;
            r_offset <= i_mix.offset;
        end
    end

    // only the low 16 bits of each shifted product reach the level
    always_comb begin
        level = r_pa[GAIN_SHIFT +: LEVEL_W] + r_pb[GAIN_SHIFT +: LEVEL_W] + r_offset;
        v     = $signed(level[LEVEL_W-1:2]);
        v_min = r_tag.is_motor ? V_MIN_MOTOR : V_MIN_LIGHT;
        if (v > V_MAX) begin
            value = VAL_W'(V_MAX);
        end else if (v < v_min) begin
            value = VAL_W'(v_min);
        end else begin
            value = v[VAL_W-1:0];
        end
    end

    assign o_res.vld   = r_tag.vld;
    assign o_res.slot  = (r_tag.is_motor ? SLOT_MOTOR_BASE : SLOT_LIGHT_BASE)
                         + SLOT_W'(r_tag.chan);
    assign o_res.value = value;
    assign o_res.level = level;

endmodule

/* design/smoothed_noise_modulator.sv */
// Smoothed noise modulator: drifting random levels for DMX light and motor slots.
// Input stream: one request per transfer; tuser carries the request kind (light
// update, motor update, light parameter write), tdata the channel, two noise
// samples and the new light parameters. Output stream: one result per update that
// is in range and taken while automatic mode is on; parameter writes and ignored
// requests give none. Configuration channel: motor gain, motor order and the
// automatic-mode enable, always ready; the user must write them only while the
// block is idle; the block itself does not enforce it. A request passes the input
// register, the cascade stages, the mix register and the output register to o_m_tvalid.
// Throughput: one request per cycle to different channels or motors while the
// output does not stall. An update waits while an earlier one on its row is
// between the accumulator read on acceptance and the write-back at the second stage.
// Reset clears all accumulators and light parameters (valid bits in flip-flops,
// no clearing pass) and loads the default motor settings.
// When the receiver stalls, the result holds in the output register; requests are
// still taken until a finished result reaches the last stage behind it, then the
// whole pipeline holds.
module smoothed_noise_modulator import snm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [2:0] chan_index, [19:3] noise_a, [36:20] noise_b, [52:37] level_offset,
    // [68:53] gain_a, [72:69] order_a, [88:73] gain_b, [92:89] order_b, [95:93] zero
    input  logic [95:0]           i_s_tdata,
    // [1:0] req_type
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [5:0] dmx_slot, [13:6] dmx_value, [29:14] level, [31:30] zero
    output logic [31:0]           o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic signed [GAIN_W-1:0] r_motor_gain;
    logic [ORD_W-1:0]         r_motor_order;
    logic                     r_auto_en;

    // request decode
    logic [CH_W-1:0]           in_ch;
    logic signed [NOISE_W-1:0] in_noise_a, in_noise_b;
    t_par                      in_par_data;
    logic                      in_range, in_upd, in_par;
    t_tag                      in_tag;
    logic [ROW_W-1:0]          in_row;
    logic                      hazard, s_acc;

    // pipeline control
    logic                      out_free, adv;
    t_tag                      r_p1_tag;
    logic signed [NOISE_W-1:0] r_noise_a, r_noise_b;
    t_acc_row                  acc_rd;
    t_par                      par_rd;
    t_coef                     coef;
    t_tag                      p2_tag;
    t_acc_wr                   acc_wr;
    t_mix_in                   mix;
    t_res                      res;
    t_res                      r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_gain  <= MOTOR_GAIN_RST;
            r_motor_order <= MOTOR_ORDER_RST;
            r_auto_en     <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MOTOR_GAIN:  r_motor_gain  <= $signed(i_cfg_data);
                CFG_MOTOR_ORDER: r_motor_order <= i_cfg_data[ORD_W-1:0];
                CFG_AUTO_EN:     r_auto_en     <= i_cfg_data[0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // unpack the request
    always_comb begin
        in_ch              = i_s_tdata[2:0];
        in_noise_a         = $signed(i_s_tdata[19:3]);
        in_noise_b         = $signed(i_s_tdata[36:20]);
        in_par_data.offset = i_s_tdata[52:37];
        in_par_data.gain_a = i_s_tdata[68:53];
        in_par_data.ord_a  = i_s_tdata[72:69];
        in_par_data.gain_b = i_s_tdata[88:73];
        in_par_data.ord_b  = i_s_tdata[92:89];
        in_range = {1'b0, in_ch} < ROW_W'(NUM_CHANNELS);
        in_upd   = in_range && r_auto_en
                   && (i_s_tuser == REQ_LIGHT || i_s_tuser == REQ_MOTOR);
        in_par   = in_range && (i_s_tuser == REQ_PARAM);
        in_tag.vld      = in_upd;
        in_tag.is_motor = (i_s_tuser == REQ_MOTOR);
        in_tag.chan     = in_ch;
        in_row          = row_of(in_tag);
    end

    // hold an update while an earlier request on its row has not yet written back
    assign hazard = in_upd && ((r_p1_tag.vld && row_of(r_p1_tag) == in_row)
                               || (p2_tag.vld && row_of(p2_tag) == in_row));

    // advance unless a finished result is blocked behind a full output register
    assign out_free   = !r_out.vld || i_m_tready;
    assign adv        = out_free || !res.vld;
    assign o_s_tready = adv && !hazard;
    assign s_acc      = i_s_tvalid && o_s_tready;

    snm_acc_mem u_acc_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (adv),
        .i_rd_row  (in_row),
        .o_rd_data (acc_rd),
        .i_wr      (acc_wr)
    );

    // parameter writes land at acceptance, ahead of any later read
    snm_par_mem u_par_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (adv),
        .i_rd_chan (in_ch),
        .o_rd_data (par_rd),
        .i_wr_en   (s_acc && in_par),
        .i_wr_chan (in_ch),
        .i_wr_data (in_par_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_tag <= '0;
        end else if (adv) begin
            r_p1_tag <= '{vld: s_acc && in_upd, is_motor: in_tag.is_motor,
                          chan: in_tag.chan};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_noise_a <= in_noise_a;
            r_noise_b <= in_noise_b;
        end
    end

    // a motor runs the first lane only: the second lane's gain is zero
    always_comb begin
        if (r_p1_tag.is_motor) begin
            coef.k1a    = {1'b0, r_motor_order};
            coef.k2a    = {1'b0, r_motor_order} + SH_W'(1);
            coef.k1b    = {1'b0, r_motor_order};
            coef.k2b    = {1'b0, r_motor_order} + SH_W'(1);
            coef.gain_a = r_motor_gain;
            coef.gain_b = '0;
            coef.offset = MOTOR_OFFSET;
        end else begin
            coef.k1a    = {1'b0, par_rd.ord_a};
            coef.k2a    = {1'b0, par_rd.ord_a};
            coef.k1b    = {1'b0, par_rd.ord_b};
            coef.k2b    = {1'b0, par_rd.ord_b} + SH_W'(1);
            coef.gain_a = $signed(par_rd.gain_a);
            coef.gain_b = $signed(par_rd.gain_b);
            coef.offset = $signed(par_rd.offset);
        end
    end

    snm_cascade u_cascade (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_tag     (r_p1_tag),
        .i_acc     (acc_rd),
        .i_noise_a (r_noise_a),
        .i_noise_b (r_noise_b),
        .i_coef    (coef),
        .o_p2_tag  (p2_tag),
        .o_wr      (acc_wr),
        .o_mix     (mix)
    );

    snm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_mix   (mix),
        .o_res   (res)
    );

    // output register: load whenever the slot is free, hold otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (out_free) begin
            r_out.vld <= res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out.slot  <= res.slot;
            r_out.value <= res.value;
            r_out.level <= res.level;
        end
    end

    assign o_m_tvalid = r_out.vld;
    assign o_m_tdata  = {2'b00, r_out.level, r_out.value, r_out.slot};

`include "assert_macros.svh"

    `SNM_ASSERT_IMP(a_no_rmw_overlap, acc_wr.en && s_acc && in_upd, acc_wr.row != in_row, "update read a row whose write-back was pending")
    `SNM_ASSERT_IMP(a_motor_floor, r_out.vld && r_out.slot < SLOT_LIGHT_BASE, r_out.value != '0, "motor slot value below one")
    `SNM_ASSERT_IMP(a_stall_blocks_input, !out_free && res.vld, !o_s_tready, "request taken while pipeline was blocked")

endmodule

/* verif/snm_level_checker.sv */
module snm_level_checker import snm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [95:0]           i_s_tdata,
    input  logic [1:0]            i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [31:0]           i_m_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MOTOR_ROW = 4 * NUM_CHANNELS;

    typedef struct {
        logic [SLOT_W-1:0]         slot;
        logic [VAL_W-1:0]          value;
        logic signed [LEVEL_W-1:0] level;
    } t_slot_write;

    // light channel c uses rows 4c..4c+3, motor m rows MOTOR_ROW+2m..+1
    logic signed [ACC_W-1:0]   filt_acc [MOTOR_ROW + 2 * NUM_CHANNELS];
    logic signed [LEVEL_W-1:0] lt_offset [NUM_CHANNELS];
    logic signed [GAIN_W-1:0]  lt_gain_a [NUM_CHANNELS];
    logic signed [GAIN_W-1:0]  lt_gain_b [NUM_CHANNELS];
    logic [ORD_W-1:0]          lt_ord_a [NUM_CHANNELS];
    logic [ORD_W-1:0]          lt_ord_b [NUM_CHANNELS];
    logic signed [GAIN_W-1:0]  mot_gain;
    logic [ORD_W-1:0]          mot_order;
    logic                      auto_on;

    t_slot_write expected_writes [$];
    t_slot_write seen;
    t_slot_write want;

    // two leaky stages in series; updates both accumulators
    function automatic logic signed [ACC_W-1:0] filter_cascade(input int row, input int k1,
                                                              input int k2,
                                                              input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] y;
        filt_acc[row] = filt_acc[row] - (filt_acc[row] >>> k1) + x;
        y = filt_acc[row] >>> k1;
        filt_acc[row+1] = filt_acc[row+1] - (filt_acc[row+1] >>> k2) + y;
        return filt_acc[row+1] >>> k2;
    endfunction

    function automatic longint gain_term(input logic signed [ACC_W-1:0] y,
                                         input logic signed [GAIN_W-1:0] g);
        longint p;
        p = longint'(y) * longint'(g);
        return p >>> GAIN_SHIFT;
    endfunction

    task automatic predict_request(input logic [1:0] kind, input logic [95:0] d);
        logic [CH_W-1:0]         ch;
        logic signed [ACC_W-1:0] na, nb, ya, yb;
        longint                  sum;
        int                      q;
        t_slot_write             w;
        ch = d[2:0];
        na = {{(ACC_W-NOISE_W){d[19]}}, d[19:3]};
        nb = {{(ACC_W-NOISE_W){d[36]}}, d[36:20]};
        if (ch >= NUM_CHANNELS) return;
        if (kind == REQ_PARAM) begin
            lt_offset[ch] = d[52:37];
            lt_gain_a[ch] = d[68:53];
            lt_ord_a[ch]  = d[72:69];
            lt_gain_b[ch] = d[88:73];
            lt_ord_b[ch]  = d[92:89];
            return;
        end
        if (!auto_on || (kind != REQ_LIGHT && kind != REQ_MOTOR)) return;
        if (kind == REQ_LIGHT) begin
            ya = filter_cascade(4 * ch, lt_ord_a[ch], lt_ord_a[ch], na);
            yb = filter_cascade(4 * ch + 2, lt_ord_b[ch], int'(lt_ord_b[ch]) + 1, nb);
            sum = gain_term(ya, lt_gain_a[ch]) + gain_term(yb, lt_gain_b[ch])
                + longint'(lt_offset[ch]);
            w.level = 16'(sum);
            q = int'(w.level) >>> 2;
            if (q < 0) q = 0;
            w.slot = 6'(SLOT_LIGHT_BASE + ch);
        end else begin
            ya = filter_cascade(MOTOR_ROW + 2 * ch, mot_order, int'(mot_order) + 1, na);
            sum = gain_term(ya, mot_gain) + longint'(MOTOR_OFFSET);
            w.level = 16'(sum);
            q = int'(w.level) >>> 2;
            if (q < 1) q = 1;
            w.slot = 6'(SLOT_MOTOR_BASE + ch);
        end
        if (q > 255) q = 255;
        w.value = 8'(q);
        expected_writes.push_back(w);
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
            o_mismatches++;
        end
    endtask

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (filt_acc[i]) filt_acc[i] = '0;
            foreach (lt_offset[i]) begin
                lt_offset[i] = '0;
                lt_gain_a[i] = '0;
                lt_gain_b[i] = '0;
                lt_ord_a[i]  = '0;
                lt_ord_b[i]  = '0;
            end
            mot_gain  = MOTOR_GAIN_RST;
            mot_order = MOTOR_ORDER_RST;
            auto_on   = 1'b1;
            expected_writes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MOTOR_GAIN:  mot_gain  = i_cfg_data;
                    CFG_MOTOR_ORDER: mot_order = i_cfg_data[ORD_W-1:0];
                    CFG_AUTO_EN:     auto_on   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_request(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                seen.slot  = i_m_tdata[5:0];
                seen.value = i_m_tdata[13:6];
                seen.level = i_m_tdata[29:14];
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got slot %0d value %0d",
                             $time, seen.slot, seen.value);
                    o_mismatches++;
                end else begin
                    want = expected_writes.pop_front();
                    check_field("dmx_slot", want.slot, seen.slot);
                    check_field("dmx_value", want.value, seen.value);
                    check_field("level", int'(want.level), int'(seen.level));
                end
            end
        end
        o_outstanding = expected_writes.size();
    end

endmodule

/* verif/smoothed_noise_modulator_tb.sv */
module smoothed_noise_modulator_tb;
    import snm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // request kind that the block must ignore
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    // cycles the receiver holds off in the back-pressure test
    localparam int HOLD_CYCLES = 300;
    // cycles to let in-flight requests settle before a register write
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [95:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    bit calm;      // no new random gaps drawn on either side while set
    bit hold_off;  // ask the receiver for one long stall

    smoothed_noise_modulator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    snm_level_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    // Noise mostly in the range -32767 to 32768; sometimes any 17-bit pattern.
    function automatic logic [NOISE_W-1:0] rand_noise();
        if ($urandom_range(0, 9) == 0) return NOISE_W'($urandom);
        return NOISE_W'($urandom_range(0, 65535) - 32767);
    endfunction

    // Gains and offsets: now and then an extreme, otherwise any value.
    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // Offer one request from a falling edge and hold it until taken. Leave valid
    // high on return unless a gap is drawn, so that back-to-back requests follow.
    task automatic offer(input logic [1:0] kind, input logic [CH_W-1:0] ch,
                         input logic [NOISE_W-1:0] na, input logic [NOISE_W-1:0] nb,
                         input logic [15:0] off, input logic [15:0] ga,
                         input logic [3:0] oa, input logic [15:0] gb,
                         input logic [3:0] ob);
        s_tuser  = kind;
        s_tdata  = {3'b000, ob, gb, oa, ga, off, nb, na, ch};
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 2) == 0) begin
            s_tvalid = 1'b0;
            repeat (gap_len()) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait at a falling edge until every predicted result is back.
    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Registers change only with the block idle: drain, let parameter writes and
    // ignored requests clear the pipeline, then write.
    task automatic set_config(input logic [15:0] gain, input logic [3:0] order, input logic en);
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_write(CFG_MOTOR_GAIN, gain);
        cfg_write(CFG_MOTOR_ORDER, CFG_DATA_W'(order));
        cfg_write(CFG_AUTO_EN, CFG_DATA_W'(en));
    endtask

    // Random traffic: mostly updates on valid channels with parameter writes mixed
    // in, plus a share of requests the block must ignore.
    task automatic random_requests(input int count);
        int              r;
        logic [1:0]      kind;
        logic [CH_W-1:0] ch;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            r  = $urandom_range(0, 99);
            ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
            if (r < 48) kind = REQ_LIGHT;
            else if (r < 84) kind = REQ_MOTOR;
            else if (r < 94) kind = REQ_PARAM;
            else if (r < 97) begin
                kind = REQ_UNKNOWN;
                ch   = CH_W'($urandom);
            end else begin
                kind = 2'($urandom_range(0, 2));
                ch   = CH_W'($urandom_range(NUM_CHANNELS, 7));
            end
            offer(kind, ch, rand_noise(), rand_noise(), rand_gain(), rand_gain(),
                  4'($urandom), rand_gain(), 4'($urandom));
        end
        calm = 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        bit held;
        m_tready   = 1'b0;
        stall_left = 0;
        held       = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off && !held) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held     = 1'b1;
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    initial begin
        #5_000_000;
        $display("smoothed_noise_modulator_tb: done, errors");
        $finish;
    end

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_LIGHT;
        cfg_valid = 1'b0;
        cfg_index = CFG_MOTOR_GAIN;
        cfg_data  = '0;
        calm      = 1'b1;
        hold_off  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, reset settings. Light parameters are still zero: level 0.
        offer(REQ_LIGHT, 3'd0, 17'sd32768, -17'sd32767, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        offer(REQ_MOTOR, 3'd0, 17'sd32768, 17'sd32768, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        offer(REQ_MOTOR, 3'd5, -17'sd32767, -17'sd32767, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        // Parameter extremes, then updates through them.
        offer(REQ_PARAM, 3'd1, 17'h0, 17'h0, 16'h7fff, 16'h7fff, 4'd0, 16'h8000, 4'd15);
        offer(REQ_LIGHT, 3'd1, 17'sd32768, -17'sd32767, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        offer(REQ_LIGHT, 3'd1, -17'sd32767, 17'sd32768, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        offer(REQ_PARAM, 3'd2, 17'h0, 17'h0, 16'h8000, 16'h8000, 4'd15, 16'h7fff, 4'd0);
        offer(REQ_LIGHT, 3'd2, 17'sd32768, 17'sd32768, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        offer(REQ_LIGHT, 3'd2, -17'sd32767, -17'sd32767, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        // Top value 255 through the offset alone, then a negative level clamped to zero.
        offer(REQ_PARAM, 3'd3, 17'h0, 17'h0, 16'd1020, 16'h0, 4'd3, 16'h0, 4'd3);
        offer(REQ_LIGHT, 3'd3, 17'sd1000, 17'sd1000, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        offer(REQ_PARAM, 3'd3, 17'h0, 17'h0, 16'hfffc, 16'h0, 4'd3, 16'h0, 4'd3);
        offer(REQ_LIGHT, 3'd3, 17'sd1000, 17'sd1000, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        // Channel out of range and unknown kind: dropped; then a valid light update.
        offer(REQ_PARAM, 3'd7, 17'h1ffff, 17'h1ffff, 16'hffff, 16'hffff, 4'd15, 16'hffff,
              4'd15);
        offer(REQ_LIGHT, 3'd6, 17'h1ffff, 17'h1ffff, 16'hffff, 16'hffff, 4'd15, 16'hffff,
              4'd15);
        offer(REQ_MOTOR, 3'd7, 17'sd5, 17'sd5, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        offer(REQ_UNKNOWN, 3'd0, 17'sd5, 17'sd5, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        offer(REQ_LIGHT, 3'd0, 17'sd5, 17'sd5, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);

        // Disabled: updates change nothing, the parameter write still lands.
        set_config(16'd2000, 4'd10, 1'b0);
        offer(REQ_LIGHT, 3'd4, 17'sd32768, 17'sd32768, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        offer(REQ_MOTOR, 3'd4, 17'sd32768, 17'sd32768, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        offer(REQ_PARAM, 3'd4, 17'h0, 17'h0, 16'd200, 16'd4096, 4'd1, 16'hf000, 4'd2);
        set_config(16'd2000, 4'd10, 1'b1);
        offer(REQ_LIGHT, 3'd4, 17'sd30000, -17'sd20000, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        offer(REQ_MOTOR, 3'd4, 17'sd30000, 17'sd0, 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        calm = 1'b0;

        // Random phases, one register setting each.
        random_requests(PHASE_ITEMS);

        set_config(16'h7fff, 4'd15, 1'b1);
        random_requests(PHASE_ITEMS);

        set_config(16'h8000, 4'd0, 1'b1);
        // Back-pressure: stall the receiver while requests keep coming, so the
        // pipeline fills and the input stalls; then pause until all is back.
        calm     = 1'b1;
        hold_off = 1'b1;
        for (int n = 0; n < 40; n++)
            offer((n % 3 == 0) ? REQ_LIGHT : REQ_MOTOR, CH_W'(n % NUM_CHANNELS),
                  rand_noise(), rand_noise(), 16'h0, 16'h0, 4'd0, 16'h0, 4'd0);
        drain();
        hold_off = 1'b0;
        calm     = 1'b0;
        random_requests(PHASE_ITEMS);

        set_config(GAIN_W'($urandom), 4'($urandom), 1'b1);
        random_requests(PHASE_ITEMS);

        set_config(GAIN_W'($urandom), 4'($urandom), 1'b0);
        random_requests(40);

        set_config(16'd1, 4'd4, 1'b1);
        random_requests(PHASE_ITEMS);

        drain();
        repeat (12) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("smoothed_noise_modulator_tb: done, clean");
        end else begin
            $display("smoothed_noise_modulator_tb: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/snm_pkg.sv
design/snm_acc_mem.sv
design/snm_par_mem.sv
design/snm_cascade.sv
design/snm_mix.sv
design/smoothed_noise_modulator.sv
verif/snm_level_checker.sv
verif/smoothed_noise_modulator_tb.sv
